// ===== rtl/msi_vector_allocator_assert.svh =====
// Assertion macros used by the vector allocator sequencer RTL.
`ifndef MSI_VECTOR_ALLOCATOR_ASSERT_SVH
`define MSI_VECTOR_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSI_VA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msi_vector_allocator: assertion failed");

// Next-cycle implication, checked out of reset.
`define MSI_VA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msi_vector_allocator: assertion failed");

`endif

// ===== rtl/msi_va_pkg.sv =====
// Package: constants, codes and types of the vector allocator.
`default_nettype none
package msi_va_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned OwnerBitsDef  = 8;
  localparam int unsigned IdxW          = 11;
  localparam int unsigned ReqW          = 9;
  localparam int unsigned VnumW         = 17;
  localparam int unsigned FvnW          = 16;
  localparam int unsigned CfgW          = 16;
  localparam int unsigned VcW           = 9;
  localparam logic [VcW-1:0] VectorCountRst = 9'd256;

  typedef enum logic [1:0] {
    OP_MSI    = 2'd0,
    OP_MSIX   = 2'd1,
    OP_FREE   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic {
    REG_VECTOR_COUNT = 1'b0,
    REG_FIRST_VECTOR = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    PH_MSI_SCAN,
    PH_MSI_CLAIM,
    PH_MSX_COUNT,
    PH_MSX_CLAIM,
    PH_FREE,
    PH_LOOK
  } phase_e;

  // Result bundle from the sequencer.
  typedef struct packed {
    logic             done;
    logic             status;
    logic [ReqW-1:0]  granted;
    logic [VnumW-1:0] vnum;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/msi_va_mem.sv =====
// Vector table memory: one write port, one registered read port.
`default_nettype none
module msi_va_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 20
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/msi_va_ctrl.sv =====
// Request sequencer: scans, claims, frees and looks up table entries through the memory.
`default_nettype none
`include "msi_vector_allocator_assert.svh"
module msi_va_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned OWNER_BITS  = 8,
  parameter int unsigned AW          = 8,
  parameter int unsigned CW          = 9,
  parameter int unsigned DW          = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [OWNER_BITS-1:0]         owner_i,
  input  wire logic [msi_va_pkg::IdxW-1:0]   idx_i,
  input  wire logic [msi_va_pkg::ReqW-1:0]   req_i,
  input  wire logic                          strict_i,
  input  wire logic [CW-1:0]                 n_i,
  input  wire logic [msi_va_pkg::FvnW-1:0]   fvn_i,
  output logic                               busy_o,
  output msi_va_pkg::result_t                res_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic [DW-1:0]                      mem_wdata_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  wire logic [DW-1:0]                 mem_rdata_i
);

  localparam int unsigned IW = msi_va_pkg::IdxW;
  localparam int unsigned RW = msi_va_pkg::ReqW;
  localparam int unsigned SW = ((CW > RW) ? CW : RW) + 1;

  msi_va_pkg::state_e state_q, state_d;
  msi_va_pkg::phase_e phase_q, phase_d;
  msi_va_pkg::op_e    op_q, op_d;

  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [RW-1:0]         req_q, req_d;
  logic                  strict_q, strict_d;
  logic [CW-1:0]         n_q, n_d;
  logic [SW-1:0]         pos_q, pos_d;
  logic [SW-1:0]         first_q, first_d;
  logic [RW-1:0]         size_q, size_d;
  logic [RW-1:0]         cnt_q, cnt_d;
  logic [RW-1:0]         k_q, k_d;
  logic [RW-1:0]         granted_q, granted_d;
  logic                  status_q, status_d;
  logic [msi_va_pkg::VnumW-1:0] vnum_q, vnum_d;

  logic [SW-1:0]         addr_cur;
  logic [SW-1:0]         n_ext;
  logic [SW-1:0]         blk_end;
  logic                  rd_use;
  logic [OWNER_BITS-1:0] rd_own;
  logic [IW-1:0]         rd_li;
  logic                  rd_match_rng;
  logic                  rd_match_idx;
  logic [DW-1:0]         claim_word;

  // MSI-X walks downward from the top of the table.
  assign addr_cur = (phase_q == msi_va_pkg::PH_MSX_COUNT || phase_q == msi_va_pkg::PH_MSX_CLAIM)
                    ? pos_q - SW'(1) : pos_q;
  assign n_ext    = SW'(n_q);
  assign blk_end  = first_q + SW'(size_q);

  assign rd_use = mem_rdata_i[DW-1];
  assign rd_own = mem_rdata_i[IW +: OWNER_BITS];
  assign rd_li  = mem_rdata_i[IW-1:0];

  assign rd_match_rng = (rd_own == owner_q) && (rd_li >= idx_q) &&
                        ({1'b0, rd_li} < ({1'b0, idx_q} + (IW + 1)'(req_q)));
  assign rd_match_idx = (rd_own == owner_q) && (rd_li == idx_q);
  assign claim_word   = {1'b1, owner_q, idx_q + IW'(k_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msi_va_pkg::ST_CLEAR;
      phase_q <= msi_va_pkg::PH_MSI_SCAN;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    owner_q   <= owner_d;
    idx_q     <= idx_d;
    req_q     <= req_d;
    strict_q  <= strict_d;
    n_q       <= n_d;
    first_q   <= first_d;
    size_q    <= size_d;
    cnt_q     <= cnt_d;
    k_q       <= k_d;
    granted_q <= granted_d;
    status_q  <= status_d;
    vnum_q    <= vnum_d;
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    op_d      = op_q;
    owner_d   = owner_q;
    idx_d     = idx_q;
    req_d     = req_q;
    strict_d  = strict_q;
    n_d       = n_q;
    pos_d     = pos_q;
    first_d   = first_q;
    size_d    = size_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    granted_d = granted_q;
    status_d  = status_q;
    vnum_d    = vnum_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_cur[AW-1:0];
    mem_wdata_o = '0;
    mem_raddr_o = addr_cur[AW-1:0];

    unique case (state_q)
      msi_va_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[AW-1:0];
        if (pos_q == SW'(TABLE_DEPTH - 1)) begin
          pos_d   = '0;
          state_d = msi_va_pkg::ST_IDLE;
        end else begin
          pos_d = pos_q + SW'(1);
        end
      end

      msi_va_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d      = msi_va_pkg::op_e'(opcode_i);
          owner_d   = owner_i;
          idx_d     = idx_i;
          req_d     = req_i;
          strict_d  = strict_i;
          n_d       = n_i;
          pos_d     = '0;
          first_d   = '0;
          size_d    = req_i;
          cnt_d     = '0;
          k_d       = '0;
          granted_d = '0;
          status_d  = 1'b1;
          vnum_d    = '0;
          state_d   = msi_va_pkg::ST_RD;
          unique case (msi_va_pkg::op_e'(opcode_i))
            msi_va_pkg::OP_MSI: begin
              phase_d = msi_va_pkg::PH_MSI_SCAN;
              if (req_i == '0) begin
                state_d = msi_va_pkg::ST_FIN;
              end
            end
            msi_va_pkg::OP_MSIX: begin
              phase_d = msi_va_pkg::PH_MSX_COUNT;
              pos_d   = SW'(n_i);
            end
            msi_va_pkg::OP_FREE:   phase_d = msi_va_pkg::PH_FREE;
            msi_va_pkg::OP_LOOKUP: phase_d = msi_va_pkg::PH_LOOK;
            default:               phase_d = msi_va_pkg::PH_LOOK;
          endcase
        end
      end

      msi_va_pkg::ST_RD: begin
        case (phase_q)
          msi_va_pkg::PH_MSI_SCAN: begin
            if (blk_end > n_ext) begin
              // block runs past the table: halve and rescan from zero
              size_d  = size_q >> 1;
              first_d = '0;
              pos_d   = '0;
              if (size_q[RW-1:1] == '0) begin
                state_d = msi_va_pkg::ST_FIN;
              end
            end else if (pos_q == blk_end) begin
              granted_d = size_q;
              if (strict_q && size_q != req_q) begin
                state_d = msi_va_pkg::ST_FIN;
              end else begin
                phase_d = msi_va_pkg::PH_MSI_CLAIM;
                pos_d   = first_q;
                k_d     = '0;
              end
            end else begin
              state_d = msi_va_pkg::ST_EV;
            end
          end
          msi_va_pkg::PH_MSI_CLAIM: begin
            if (k_q == size_q) begin
              status_d = 1'b0;
              state_d  = msi_va_pkg::ST_FIN;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = claim_word;
              pos_d       = pos_q + SW'(1);
              k_d         = k_q + RW'(1);
            end
          end
          msi_va_pkg::PH_MSX_COUNT: begin
            if (pos_q == '0 || cnt_q == req_q) begin
              granted_d = cnt_q;
              if (cnt_q == '0 || (strict_q && cnt_q != req_q)) begin
                state_d = msi_va_pkg::ST_FIN;
              end else begin
                phase_d = msi_va_pkg::PH_MSX_CLAIM;
                pos_d   = n_ext;
                k_d     = '0;
              end
            end else begin
              state_d = msi_va_pkg::ST_EV;
            end
          end
          msi_va_pkg::PH_MSX_CLAIM: begin
            if (k_q == cnt_q || pos_q == '0) begin
              status_d = 1'b0;
              state_d  = msi_va_pkg::ST_FIN;
            end else begin
              state_d = msi_va_pkg::ST_EV;
            end
          end
          msi_va_pkg::PH_FREE: begin
            if (pos_q == n_ext || k_q == req_q) begin
              status_d = (k_q < req_q);
              state_d  = msi_va_pkg::ST_FIN;
            end else begin
              state_d = msi_va_pkg::ST_EV;
            end
          end
          default: begin
            if (pos_q == n_ext) begin
              state_d = msi_va_pkg::ST_FIN;
            end else begin
              state_d = msi_va_pkg::ST_EV;
            end
          end
        endcase
      end

      msi_va_pkg::ST_EV: begin
        state_d = msi_va_pkg::ST_RD;
        case (phase_q)
          msi_va_pkg::PH_MSI_SCAN: begin
            if (rd_use) begin
              first_d = blk_end;
              pos_d   = blk_end;
            end else begin
              pos_d = pos_q + SW'(1);
            end
          end
          msi_va_pkg::PH_MSX_COUNT: begin
            if (!rd_use) begin
              cnt_d = cnt_q + RW'(1);
            end
            pos_d = pos_q - SW'(1);
          end
          msi_va_pkg::PH_MSX_CLAIM: begin
            if (!rd_use) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = claim_word;
              k_d         = k_q + RW'(1);
            end
            pos_d = pos_q - SW'(1);
          end
          msi_va_pkg::PH_FREE: begin
            if (rd_match_rng) begin
              mem_we_o = 1'b1;
              k_d      = k_q + RW'(1);
            end
            pos_d = pos_q + SW'(1);
          end
          msi_va_pkg::PH_LOOK: begin
            if (rd_match_idx) begin
              vnum_d   = msi_va_pkg::VnumW'(fvn_i) + msi_va_pkg::VnumW'(pos_q);
              status_d = 1'b0;
              state_d  = msi_va_pkg::ST_FIN;
            end else begin
              pos_d = pos_q + SW'(1);
            end
          end
          default: ;
        endcase
      end

      msi_va_pkg::ST_FIN: begin
        state_d = msi_va_pkg::ST_IDLE;
      end

      default: state_d = msi_va_pkg::ST_IDLE;
    endcase
  end

  assign busy_o        = (state_q != msi_va_pkg::ST_IDLE);
  assign res_o.done    = (state_q == msi_va_pkg::ST_FIN);
  assign res_o.status  = status_q;
  assign res_o.granted = granted_q;
  assign res_o.vnum    = vnum_q;

  `MSI_VA_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `MSI_VA_ASSERT_NOW(a_idle_no_write, state_q == msi_va_pkg::ST_IDLE, !mem_we_o)
  `MSI_VA_ASSERT_NOW(a_grant_alloc_only,
      res_o.done && (op_q == msi_va_pkg::OP_FREE || op_q == msi_va_pkg::OP_LOOKUP),
      res_o.granted == '0)
  `MSI_VA_ASSERT_NOW(a_vnum_lookup_only,
      res_o.done && op_q != msi_va_pkg::OP_LOOKUP, res_o.vnum == '0)

endmodule
`default_nettype wire

// ===== rtl/msi_vector_allocator.sv =====
// Top level of the MSI / MSI-X interrupt vector allocator.
//
//   channel   direction  handshake               payload
//   request   in         start_i & !busy_o       opcode_i owner_id_i first_local_index_i
//                                                request_count_i strict_i
//   result    out        done_o, one cycle       status_o granted_count_o vector_number_o
//   config    in         cfg_we_i                cfg_idx_i cfg_wdata_i
//
// After reset the table is swept to zero, one entry a cycle, with busy_o
// high; config writes are taken during the sweep. Every table entry visited
// goes through a memory read, then an evaluate step; MSI claims write their
// entries without the evaluate step. One item is in work at a time; the
// result is shown for one cycle on done_o and cannot be stalled.
`default_nettype none
module msi_vector_allocator #(
  parameter int unsigned TABLE_DEPTH = msi_va_pkg::TableDepthDef,
  parameter int unsigned OWNER_BITS  = msi_va_pkg::OwnerBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic [7:0]                         owner_id_i,
  input  wire logic [msi_va_pkg::IdxW-1:0]        first_local_index_i,
  input  wire logic [msi_va_pkg::ReqW-1:0]        request_count_i,
  input  wire logic                               strict_i,
  output logic                                    done_o,
  output logic                                    status_o,
  output logic [msi_va_pkg::ReqW-1:0]             granted_count_o,
  output logic [msi_va_pkg::VnumW-1:0]            vector_number_o,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_idx_i,
  input  wire logic [msi_va_pkg::CfgW-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  // entry word: {in_use, owner, local index}
  localparam int unsigned DW = 1 + OWNER_BITS + msi_va_pkg::IdxW;

  logic [msi_va_pkg::VcW-1:0]  vector_count_q;
  logic [msi_va_pkg::FvnW-1:0] first_vn_q;
  logic [CW-1:0]               n_used;
  logic [OWNER_BITS-1:0]       owner;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  msi_va_pkg::result_t res;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_count_q <= msi_va_pkg::VectorCountRst;
      first_vn_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (msi_va_pkg::reg_e'(cfg_idx_i))
        msi_va_pkg::REG_VECTOR_COUNT: vector_count_q <= cfg_wdata_i[msi_va_pkg::VcW-1:0];
        msi_va_pkg::REG_FIRST_VECTOR: first_vn_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Usable entries: vector_count clipped to the built depth.
  always_comb begin
    if (32'(vector_count_q) < TABLE_DEPTH) begin
      n_used = CW'(vector_count_q);
    end else begin
      n_used = CW'(TABLE_DEPTH);
    end
  end

  // Owner is taken modulo 2^OWNER_BITS.
  assign owner = OWNER_BITS'(owner_id_i);

  msi_va_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OWNER_BITS  (OWNER_BITS),
    .AW          (AW),
    .CW          (CW),
    .DW          (DW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .owner_i     (owner),
    .idx_i       (first_local_index_i),
    .req_i       (request_count_i),
    .strict_i    (strict_i),
    .n_i         (n_used),
    .fvn_i       (first_vn_q),
    .busy_o      (busy_o),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  msi_va_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign done_o          = res.done;
  assign status_o        = res.status;
  assign granted_count_o = res.granted;
  assign vector_number_o = res.vnum;

endmodule
`default_nettype wire
